/* rtl/sfgb_pkg.sv */
// Shared constants, register indexes and control structures of the glyph blitter.
package sfgb_pkg;

	localparam int GLYPH_STORE_BYTES = 4096;
	localparam int STORE_AW          = $clog2(GLYPH_STORE_BYTES);
	localparam int MAX_SCALE         = 4;
	localparam int MAX_ROWS          = 64;
	localparam int MAX_RUN           = 32;
	localparam int COORD_LIMIT       = 4096;
	localparam int MAX_FONT_W        = 8;
	localparam int MAX_FONT_H        = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_FONT_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FONT_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd4;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_DRAW  = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_glyph;
		logic capture;
		logic setup;
		logic fetch;
		logic load_out;
		logic advance;
	} sfgb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic reject;
		logic last;
	} sfgb_status_t;

endpackage

/* rtl/sfgb_ram.sv */
// Generic single-write, single-read memory with registered read data.
module sfgb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/sfgb_ctrl.sv */
// Controller state machine of the glyph blitter.
module sfgb_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  action,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	output sfgb_pkg::sfgb_cmd_t    cmd,
	input  sfgb_pkg::sfgb_status_t status
);
	import sfgb_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SETUP = 5'b00010,
		ST_FETCH = 5'b00100,
		ST_LOAD  = 5'b01000,
		ST_HOLD  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_HOLD);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (action == ACT_DRAW) begin
						cmd.capture = 1'b1;
						state_d     = ST_SETUP;
					end else begin
						cmd.wr_glyph = 1'b1;
					end
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = status.reject ? ST_IDLE : ST_FETCH;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load_out = 1'b1;
				state_d      = ST_HOLD;
			end
			ST_HOLD: begin
				if (!out_stall) begin
					if (status.last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = ST_FETCH;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/sfgb_dp.sv */
// Datapath of the glyph blitter: configuration, glyph store, counters and scanline build.
module sfgb_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sfgb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfgb_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [11:0]                       glyph_addr,
	input  logic [7:0]                        glyph_byte,
	input  logic [7:0]                        char_code,
	input  logic [11:0]                       pos_x,
	input  logic [11:0]                       pos_y,
	input  logic [31:0]                       ink_colour,
	input  logic [31:0]                       paper_colour,
	input  logic                              palette_flag,
	input  logic [2:0]                        scale,
	input  sfgb_pkg::sfgb_cmd_t               cmd,
	output sfgb_pkg::sfgb_status_t            status,
	output logic [11:0]                       row_y,
	output logic [11:0]                       start_x,
	output logic [5:0]                        run_width,
	output logic [31:0]                       pixel_mask,
	output logic [31:0]                       fg_out,
	output logic [31:0]                       bg_out,
	output logic                              palette_out,
	output logic                              last_row
);
	import sfgb_pkg::*;

	// Replicates each glyph column scale times, leftmost pixel in bit 0.
	function automatic logic [31:0] expand_row(input logic [7:0] bits, input logic [2:0] sc);
		logic [7:0]  rev;
		logic [31:0] m;
		int          col;
		for (int j = 0; j < 8; j++) begin
			rev[j] = bits[7-j];
		end
		m = '0;
		for (int i = 0; i < 32; i++) begin
			unique case (sc)
				3'd1:    col = i;
				3'd2:    col = i / 2;
				3'd3:    col = i / 3;
				3'd4:    col = i / 4;
				default: col = 8;
			endcase
			m[i] = (col < 8) ? rev[3'(col)] : 1'b0;
		end
		return m;
	endfunction

	logic [3:0]  font_width_q;
	logic [4:0]  font_height_q;
	logic [8:0]  glyph_count_q;
	logic [12:0] screen_width_q;
	logic [12:0] screen_height_q;

	logic [7:0]  code_q;
	logic [11:0] px_q, py_q;
	logic [2:0]  scale_q;
	logic [11:0] base_q;
	logic [6:0]  rows_q;
	logic [5:0]  run_q;
	logic [6:0]  row_q;
	logic [2:0]  sub_q;
	logic [3:0]  grow_q;

	logic [3:0]  fw_eff;
	logic [4:0]  fh_eff;
	logic [12:0] sw_eff, sh_eff;
	logic [12:0] sh_rem, sw_rem;
	logic [7:0]  fh_sc, fw_sc;
	logic [12:0] rows_a, run_a;
	logic [12:0] base_full;
	logic [2:0]  scale_sat;
	logic [7:0]  rd_byte;
	logic [31:0] run_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_width_q    <= 4'd8;
			font_height_q   <= 5'd8;
			glyph_count_q   <= 9'd0;
			screen_width_q  <= 13'd640;
			screen_height_q <= 13'd480;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FONT_WIDTH:    font_width_q    <= cfg_data[3:0];
				REG_FONT_HEIGHT:   font_height_q   <= cfg_data[4:0];
				REG_GLYPH_COUNT:   glyph_count_q   <= cfg_data[8:0];
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign fw_eff = (font_width_q > 4'(MAX_FONT_W)) ? 4'(MAX_FONT_W) : font_width_q;
	assign fh_eff = (font_height_q > 5'(MAX_FONT_H)) ? 5'(MAX_FONT_H) : font_height_q;
	assign sw_eff = (screen_width_q > 13'(COORD_LIMIT)) ? 13'(COORD_LIMIT) : screen_width_q;
	assign sh_eff = (screen_height_q > 13'(COORD_LIMIT)) ? 13'(COORD_LIMIT) : screen_height_q;

	assign scale_sat = (scale > 3'(MAX_SCALE)) ? 3'(MAX_SCALE) : scale;

	// Capture of the draw transaction; the colours go straight to the output register.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			code_q      <= char_code;
			px_q        <= pos_x;
			py_q        <= pos_y;
			scale_q     <= scale_sat;
			fg_out      <= ink_colour;
			bg_out      <= paper_colour;
			palette_out <= palette_flag;
		end
	end

	assign sw_rem    = sw_eff - {1'b0, px_q};
	assign sh_rem    = sh_eff - {1'b0, py_q};
	assign fh_sc     = 8'(fh_eff) * 8'(scale_q);
	assign fw_sc     = 8'(fw_eff) * 8'(scale_q);
	assign base_full = 13'(code_q) * 13'(fh_eff);

	always_comb begin
		rows_a = (13'(fh_sc) < sh_rem) ? 13'(fh_sc) : sh_rem;
		if (rows_a > 13'(MAX_ROWS)) begin
			rows_a = 13'(MAX_ROWS);
		end
		run_a = (13'(fw_sc) < sw_rem) ? 13'(fw_sc) : sw_rem;
		if (run_a > 13'(MAX_RUN)) begin
			run_a = 13'(MAX_RUN);
		end
	end

	assign status.reject = (scale_q == 3'd0) || ({1'b0, code_q} >= glyph_count_q)
		|| ({1'b0, px_q} >= sw_eff) || ({1'b0, py_q} >= sh_eff)
		|| (fw_eff == 4'd0) || (fh_eff == 5'd0);
	assign status.last = last_row;

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			rows_q <= rows_a[6:0];
			run_q  <= run_a[5:0];
			base_q <= base_full[STORE_AW-1:0];
			row_q  <= '0;
			sub_q  <= '0;
			grow_q <= '0;
		end else if (cmd.advance) begin
			row_q <= row_q + 7'd1;
			if (sub_q + 3'd1 == scale_q) begin
				sub_q  <= '0;
				grow_q <= grow_q + 4'd1;
			end else begin
				sub_q <= sub_q + 3'd1;
			end
		end
	end

	sfgb_ram #(
		.WIDTH(8),
		.DEPTH(GLYPH_STORE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr_glyph),
		.waddr(glyph_addr[STORE_AW-1:0]),
		.wdata(glyph_byte),
		.re   (cmd.fetch),
		.raddr(STORE_AW'(base_q + {8'd0, grow_q})),
		.rdata(rd_byte)
	);

	always_comb begin
		for (int i = 0; i < 32; i++) begin
			run_mask[i] = (6'(i) < run_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			row_y      <= py_q + {5'd0, row_q};
			start_x    <= px_q;
			run_width  <= run_q;
			pixel_mask <= expand_row(rd_byte, scale_q) & run_mask;
			last_row   <= (row_q + 7'd1 == rows_q);
		end
	end

endmodule

/* rtl/scaled_font_glyph_blitter_unit.sv */
// Top level of the scaled bitmap font glyph blitter.
//
// Channel  | Handshake              | Transaction carries
// ---------+------------------------+------------------------------------------------
// input    | in_valid / in_stall    | glyph store write or draw request
// output   | out_valid / out_stall  | one scanline: row, start, width, mask, colours
// config   | cfg_we (no handshake)  | cfg_index, cfg_data
//
// A glyph store write is taken in the idle state, which the controller does not
// leave, so writes can follow back to back. A draw passes through capture, then
// set-up and clip checks, then per scanline three steps (store read, mask build,
// output hold), waiting in the hold step for as long as out_stall is held. The
// three-step loop per scanline, with its registered store read, sets the rate.
// Reset idles the controller and presets the config registers; the glyph store holds
// garbage until written. Input transactions are taken only while no draw is in hand.
module scaled_font_glyph_blitter_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sfgb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfgb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            action,
	input  logic [11:0]                     glyph_addr,
	input  logic [7:0]                      glyph_byte,
	input  logic [7:0]                      char_code,
	input  logic [11:0]                     pos_x,
	input  logic [11:0]                     pos_y,
	input  logic [31:0]                     ink_colour,
	input  logic [31:0]                     paper_colour,
	input  logic                            palette_flag,
	input  logic [2:0]                      scale,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [11:0]                     row_y,
	output logic [11:0]                     start_x,
	output logic [5:0]                      run_width,
	output logic [31:0]                     pixel_mask,
	output logic [31:0]                     fg_out,
	output logic [31:0]                     bg_out,
	output logic                            palette_out,
	output logic                            last_row
);
	import sfgb_pkg::*;

	sfgb_cmd_t    cmd;
	sfgb_status_t status;

	// The controller sequences capture, set-up and the per-scanline fetch, build and hold.
	sfgb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.status   (status)
	);

	// The datapath holds the configuration, the glyph store, the row counters and the
	// output register from which each scanline transaction is presented.
	sfgb_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.glyph_addr  (glyph_addr),
		.glyph_byte  (glyph_byte),
		.char_code   (char_code),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.ink_colour  (ink_colour),
		.paper_colour(paper_colour),
		.palette_flag(palette_flag),
		.scale       (scale),
		.cmd         (cmd),
		.status      (status),
		.row_y       (row_y),
		.start_x     (start_x),
		.run_width   (run_width),
		.pixel_mask  (pixel_mask),
		.fg_out      (fg_out),
		.bg_out      (bg_out),
		.palette_out (palette_out),
		.last_row    (last_row)
	);

	// No input transaction is taken while a scanline is on offer.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while a scanline is pending");

	// After the final scanline of a character is taken, the block goes back to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_row) |=> (!out_valid && !in_stall))
		else $error("block not idle after the last scanline");

	// A rejected draw produces no scanline and frees the input at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.setup && status.reject) |=> (!in_stall && !out_valid))
		else $error("rejected draw did not return to idle");

	// A store read is always followed by the mask build and then an offered scanline.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |=> cmd.load_out ##1 out_valid)
		else $error("fetch not followed by a scanline");

endmodule

/* sim/scaled_font_glyph_blitter_unit_tb.sv */
// Self-checking testbench for the scaled font glyph blitter: random and directed traffic with scanline prediction.
`timescale 1ns / 1ps

module scaled_font_glyph_blitter_unit_tb;
	import sfgb_pkg::*;

	// Quiet cycles allowed before the run is declared hung. The longest correct
	// stretch without any transaction is a settle pause, the register writes, a
	// sender gap, the capture and set-up cycles and one stalled scanline, which is
	// well under this.
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	// Cycles allowed for the block to fall idle once the last scanline has gone.
	localparam int unsigned DRAIN_CYCLES   = 16;
	// Roughly thirty directed items followed by about five hundred random ones.
	localparam int unsigned ITEM_TARGET    = 530;
	// Glyph rows for the directed part: full, empty, single edge pixels and checkers.
	localparam logic [63:0] EDGE_ROWS      = 64'hFF00_8001_AA55_FF00;

	// One input transaction, either a glyph store write or a draw request.
	typedef struct packed {
		logic        act;
		logic [11:0] addr;
		logic [7:0]  gbyte;
		logic [7:0]  code;
		logic [11:0] px;
		logic [11:0] py;
		logic [31:0] fg;
		logic [31:0] bg;
		logic        pal;
		logic [2:0]  scale;
	} blit_req_t;

	// One output transaction, a single clipped scanline of a magnified glyph.
	typedef struct packed {
		logic [11:0] row_y;
		logic [11:0] start_x;
		logic [5:0]  run;
		logic [31:0] mask;
		logic [31:0] fg;
		logic [31:0] bg;
		logic        pal;
		logic        last;
	} scanline_t;

	// Shadow of the blitter: its registers, its glyph store and the scanlines
	// that are owed but have not yet been seen on the output.
	class glyph_blit_model;
		int unsigned font_w, font_h, glyph_cnt, scr_w, scr_h;
		int unsigned errors;
		logic [7:0]  glyph_mem [GLYPH_STORE_BYTES];
		scanline_t   pending_lines[$];

		function new();
			font_w    = 8;
			font_h    = 8;
			glyph_cnt = 0;
			scr_w     = 640;
			scr_h     = 480;
			errors    = 0;
		endfunction

		static function int unsigned lesser(int unsigned a, int unsigned b);
			return (a < b) ? a : b;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_FONT_WIDTH:    font_w    = val[3:0];
				REG_FONT_HEIGHT:   font_h    = val[4:0];
				REG_GLYPH_COUNT:   glyph_cnt = val[8:0];
				REG_SCREEN_WIDTH:  scr_w     = val[12:0];
				REG_SCREEN_HEIGHT: scr_h     = val[12:0];
				default: ;
			endcase
		endfunction

		// Works out the shape of a draw under the present settings. A rejected
		// draw comes back with no rows; row r reads store byte base + r / mag.
		function void plan_draw(input blit_req_t r, output int unsigned rows,
				output int unsigned run, output int unsigned mag, output int unsigned base);
			int unsigned fw, fh, sw, sh;
			rows = 0;
			run  = 0;
			mag  = 1;
			base = 0;
			if (r.act != ACT_DRAW || r.scale == 0 || r.code >= glyph_cnt)
				return;
			mag = lesser(r.scale, MAX_SCALE);
			fw  = lesser(font_w, MAX_FONT_W);
			fh  = lesser(font_h, MAX_FONT_H);
			sw  = lesser(scr_w, COORD_LIMIT);
			sh  = lesser(scr_h, COORD_LIMIT);
			if (r.px >= sw || r.py >= sh || fw == 0 || fh == 0)
				return;
			rows = lesser(lesser(fh * mag, sh - r.py), MAX_ROWS);
			run  = lesser(lesser(fw * mag, sw - r.px), MAX_RUN);
			base = r.code * fh;
		endfunction

		// Applies one accepted input transaction and queues the scanlines it owes.
		function void take_request(blit_req_t r);
			int unsigned rows, run, mag, base, a;
			logic [7:0]  bits;
			scanline_t   s;
			if (r.act == ACT_WRITE) begin
				glyph_mem[r.addr] = r.gbyte;
				return;
			end
			plan_draw(r, rows, run, mag, base);
			for (int unsigned row = 0; row < rows; row++) begin
				a      = (base + row / mag) % GLYPH_STORE_BYTES;
				bits   = glyph_mem[a];
				s.mask = '0;
				for (int unsigned i = 0; i < run; i++)
					s.mask[i] = bits[7 - i / mag];
				s.row_y   = 12'(r.py + row);
				s.start_x = r.px;
				s.run     = 6'(run);
				s.fg      = r.fg;
				s.bg      = r.bg;
				s.pal     = r.pal;
				s.last    = (row + 1 == rows);
				pending_lines.push_back(s);
			end
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			end
		endfunction

		// Compares one accepted scanline with the oldest one owed.
		function void check_scanline(scanline_t got);
			scanline_t want;
			if (pending_lines.size() == 0) begin
				errors++;
				$error("unexpected scanline: row_y %0d start_x %0d", got.row_y, got.start_x);
				return;
			end
			want = pending_lines.pop_front();
			check_field("row_y", want.row_y, got.row_y);
			check_field("start_x", want.start_x, got.start_x);
			check_field("run_width", want.run, got.run);
			check_field("pixel_mask", want.mask, got.mask);
			check_field("fg_out", want.fg, got.fg);
			check_field("bg_out", want.bg, got.bg);
			check_field("palette_out", want.pal, got.pal);
			check_field("last_row", want.last, got.last);
		endfunction
	endclass

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic                  action       = ACT_WRITE;
	logic [11:0]           glyph_addr   = '0;
	logic [7:0]            glyph_byte   = '0;
	logic [7:0]            char_code    = '0;
	logic [11:0]           pos_x        = '0;
	logic [11:0]           pos_y        = '0;
	logic [31:0]           ink_colour   = '0;
	logic [31:0]           paper_colour = '0;
	logic                  palette_flag = 1'b0;
	logic [2:0]            scale        = '0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic [11:0]           row_y;
	logic [11:0]           start_x;
	logic [5:0]            run_width;
	logic [31:0]           pixel_mask;
	logic [31:0]           fg_out;
	logic [31:0]           bg_out;
	logic                  palette_out;
	logic                  last_row;

	glyph_blit_model board = new();

	// Store bytes that have been written at least once. A draw is only sent once
	// every byte it will read has been loaded, so the store never answers with junk.
	bit          loaded [GLYPH_STORE_BYTES];
	int unsigned items_sent  = 0;
	// Per-phase switches for the random gaps on each side; with a switch off that
	// side runs flat out, which gives stretches of back-to-back transactions.
	bit          in_idle_on  = 1'b1;
	bit          out_idle_on = 1'b1;

	scaled_font_glyph_blitter_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.glyph_addr   (glyph_addr),
		.glyph_byte   (glyph_byte),
		.char_code    (char_code),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.ink_colour   (ink_colour),
		.paper_colour (paper_colour),
		.palette_flag (palette_flag),
		.scale        (scale),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.row_y        (row_y),
		.start_x      (start_x),
		.run_width    (run_width),
		.pixel_mask   (pixel_mask),
		.fg_out       (fg_out),
		.bg_out       (bg_out),
		.palette_out  (palette_out),
		.last_row     (last_row)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Every field random, so that the fields a transaction does not use are noise.
	function automatic blit_req_t random_fields();
		blit_req_t r;
		r.act   = 1'($urandom);
		r.addr  = 12'($urandom);
		r.gbyte = 8'($urandom);
		r.code  = 8'($urandom);
		r.px    = 12'($urandom);
		r.py    = 12'($urandom);
		r.fg    = $urandom;
		r.bg    = $urandom;
		r.pal   = 1'($urandom);
		r.scale = 3'($urandom);
		return r;
	endfunction

	function automatic blit_req_t draw_req(logic [7:0] code, logic [11:0] px,
			logic [11:0] py, logic [2:0] sc);
		blit_req_t r;
		r       = random_fields();
		r.act   = ACT_DRAW;
		r.code  = code;
		r.px    = px;
		r.py    = py;
		r.scale = sc;
		return r;
	endfunction

	// A coordinate below lim, drawn hard against the far edge a third of the time
	// so that the right and bottom clipping is exercised often.
	function automatic int unsigned near_edge(int unsigned lim);
		int unsigned reach;
		reach = board.lesser(lim - 1, 40);
		if ($urandom_range(0, 2) == 0)
			return lim - 1 - $urandom_range(0, reach);
		return $urandom_range(0, lim - 1);
	endfunction

	// Most draws are well formed for the present settings, so that they get past
	// the clip checks; the rest are fully random and mostly rejected.
	function automatic blit_req_t random_draw();
		int unsigned sw, sh, gc;
		sw = board.lesser(board.scr_w, COORD_LIMIT);
		sh = board.lesser(board.scr_h, COORD_LIMIT);
		gc = board.lesser(board.glyph_cnt, 256);
		if ($urandom_range(0, 3) != 0 && gc != 0 && sw != 0 && sh != 0)
			return draw_req(8'($urandom_range(0, gc - 1)), 12'(near_edge(sw)),
				12'(near_edge(sh)), 3'($urandom_range(1, MAX_SCALE)));
		return draw_req(8'($urandom), 12'($urandom), 12'($urandom), 3'($urandom));
	endfunction

	function automatic int unsigned pick_extent();
		case ($urandom_range(0, 3))
			0: return $urandom_range(1, 64);
			1: return $urandom_range(320, 1024);
			2: return $urandom_range(1, 4096);
			default: return $urandom_range(0, 8191);
		endcase
	endfunction

	// Presents one input transaction after a random gap and holds it until the
	// block takes it. The valid is left high on return: the caller either
	// presents the next transaction or lowers it within the same time step.
	task automatic send_item(blit_req_t r);
		int unsigned gap;
		gap = in_idle_on ? $urandom_range(0, 5) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= r.act;
		glyph_addr   <= r.addr;
		glyph_byte   <= r.gbyte;
		char_code    <= r.code;
		pos_x        <= r.px;
		pos_y        <= r.py;
		ink_colour   <= r.fg;
		paper_colour <= r.bg;
		palette_flag <= r.pal;
		scale        <= r.scale;
		do @(posedge clk); while (in_stall);
		board.take_request(r);
		items_sent++;
	endtask

	task automatic load_byte(logic [11:0] a, logic [7:0] b);
		blit_req_t r;
		r       = random_fields();
		r.act   = ACT_WRITE;
		r.addr  = a;
		r.gbyte = b;
		loaded[a] = 1'b1;
		send_item(r);
	endtask

	// A draw preceded by writes of random rows for any store byte it would read
	// that has never been loaded.
	task automatic send_draw(blit_req_t r);
		int unsigned rows, run, mag, base, a;
		board.plan_draw(r, rows, run, mag, base);
		for (int unsigned row = 0; row < rows; row++) begin
			a = (base + row / mag) % GLYPH_STORE_BYTES;
			if (!loaded[a])
				load_byte(12'(a), 8'($urandom));
		end
		send_item(r);
	endtask

	// Lets the block run dry: no input offered, every owed scanline seen, and
	// then a drain pause for a rejected draw or the tail of the last one.
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending_lines.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The write enable is left high between back-to-back writes and lowered by
	// the caller once the group is done.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	task automatic program_regs(input int unsigned fw, fh, gc, sw, sh);
		settle();
		write_reg(REG_FONT_WIDTH, 13'(fw));
		write_reg(REG_FONT_HEIGHT, 13'(fh));
		write_reg(REG_GLYPH_COUNT, 13'(gc));
		write_reg(REG_SCREEN_WIDTH, 13'(sw));
		write_reg(REG_SCREEN_HEIGHT, 13'(sh));
		cfg_we <= 1'b0;
	endtask

	// Output side: a random stall before each scanline, then the scanline is
	// taken and checked against the oldest one owed.
	initial begin
		int unsigned hold;
		scanline_t   seen;
		forever begin
			hold = out_idle_on ? $urandom_range(0, 5) : 0;
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
			seen = {row_y, start_x, run_width, pixel_mask, fg_out, bg_out, palette_out,
				last_row};
			board.check_scanline(seen);
		end
	end

	// Watchdog: any transaction on either channel restarts the count.
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		blit_req_t   r;
		int unsigned phase_items;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight out of reset the glyph count is zero, so a draw must be rejected.
		send_draw(draw_req(8'd0, 12'd0, 12'd0, 3'd1));

		// Open up the glyph count only, so that the other reset values are used.
		settle();
		write_reg(REG_GLYPH_COUNT, 13'd256);
		cfg_we <= 1'b0;

		// Glyph 0 of an 8-row font gets rows with edge pixels, checkers and blanks.
		for (int k = 0; k < 8; k++)
			load_byte(12'(k), EDGE_ROWS[63 - 8 * k -: 8]);

		r     = draw_req(8'd0, 12'd0, 12'd0, 3'd1);
		r.fg  = '1;
		r.bg  = '0;
		r.pal = 1'b1;
		send_draw(r);
		// A scale above the maximum is saturated: 32 rows of 32 pixels.
		r     = draw_req(8'd0, 12'd0, 12'd0, 3'd7);
		r.fg  = '0;
		r.bg  = '1;
		r.pal = 1'b0;
		send_draw(r);
		// A zero scale draws nothing.
		send_draw(draw_req(8'd0, 12'd0, 12'd0, 3'd0));
		// Near the bottom right corner, clipped on both edges.
		send_draw(draw_req(8'd0, 12'd634, 12'd476, 3'd2));
		// Just off the right edge and just off the bottom edge.
		send_draw(draw_req(8'd0, 12'd640, 12'd0, 3'd1));
		send_draw(draw_req(8'd0, 12'd0, 12'd480, 3'd1));

		// Oversized font and screen settings: the font acts as 8 by 16 and the
		// screen is clipped at 4096 in both directions. A 16-row glyph at scale 4
		// gives the full 64 scanlines; the top code at the far corner gives one pixel.
		program_regs(15, 31, 511, 8191, 8191);
		send_draw(draw_req(8'd0, 12'd0, 12'd0, 3'd4));
		send_draw(draw_req(8'd255, 12'd4095, 12'd4095, 3'd4));

		// The smallest sensible settings: a one-pixel font on a one-pixel screen.
		program_regs(1, 1, 1, 1, 1);
		send_draw(draw_req(8'd0, 12'd0, 12'd0, 3'd3));
		send_draw(draw_req(8'd1, 12'd0, 12'd0, 3'd1));

		// A zero font width, a zero font height and a zero screen each draw nothing.
		program_regs(0, 8, 256, 640, 480);
		send_draw(draw_req(8'd0, 12'd8, 12'd8, 3'd1));
		program_regs(8, 0, 256, 640, 480);
		send_draw(draw_req(8'd0, 12'd8, 12'd8, 3'd1));
		program_regs(8, 8, 256, 0, 0);
		send_draw(draw_req(8'd0, 12'd0, 12'd0, 3'd1));

		// Random phases: fresh settings, fresh idling behaviour on both sides, and
		// then a run of mostly well-formed draws with the odd stray store write.
		while (items_sent < ITEM_TARGET) begin
			program_regs(
				($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8),
				($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16),
				($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 256),
				pick_extent(), pick_extent());
			in_idle_on  = ($urandom_range(0, 3) != 0);
			out_idle_on = ($urandom_range(0, 3) != 0);
			phase_items = $urandom_range(20, 60);
			for (int unsigned n = 0; n < phase_items && items_sent < ITEM_TARGET; n++) begin
				if ($urandom_range(0, 7) == 0)
					load_byte(12'($urandom), 8'($urandom));
				else
					send_draw(random_draw());
			end
		end

		settle();
		if (board.errors == 0 && board.pending_lines.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
